// ===== hw/rtl/standby_parent_selector_unit_defines.svh =====
// assertion macros for the standby parent selector
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef STANDBY_PARENT_SELECTOR_UNIT_DEFINES_SVH
`define STANDBY_PARENT_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/spsu_pkg.sv =====
// shared types, constants and the score function of the standby parent selector
// no dependencies
`timescale 1ns / 1ps

package spsu_pkg;

    // command codes
    localparam logic [1:0] CMD_OBSERVE  = 2'd0;
    localparam logic [1:0] CMD_FAILOVER = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TIMEOUT = 2'd1;
    localparam int CFG_DATA_W = 32;

    // reset values and special addresses
    localparam logic [7:0]  RST_REPLACE_MARGIN = 8'd10;
    localparam logic [31:0] RST_REFRESH_TIMEOUT = 32'd30000;
    localparam logic [15:0] ADDR_NONE = 16'hFFFF;
    localparam logic [15:0] ADDR_INVALID = 16'hFFFE;
    localparam logic signed [7:0] DEFAULT_SIGNAL = -8'sd127;
    localparam logic signed [7:0] DEFAULT_SCORE = -8'sd63;
    localparam logic [31:0] FRESH_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        now_ms;
        logic [15:0]        node_addr;
        logic signed [7:0]  margin;
        logic signed [7:0]  signal_level;
        logic               ext_present;
        logic [63:0]        ext_addr;
    } t_in_item;

    typedef struct packed {
        logic               standby_ok;
        logic [15:0]        standby_addr;
        logic signed [7:0]  standby_score;
        logic signed [7:0]  standby_margin;
        logic signed [7:0]  standby_signal;
        logic               standby_has_ext;
        logic [63:0]        standby_ext;
        logic [31:0]        freshness_ms;
    } t_out_item;

    // stored standby entry
    typedef struct packed {
        logic               valid;
        logic [15:0]        addr;
        logic signed [7:0]  margin;
        logic signed [7:0]  signal;
        logic signed [7:0]  score;
        logic [31:0]        stamp;
        logic               ext_known;
        logic [63:0]        ext;
    } t_cand_state;

    // margin plus signal halved toward zero, wrapped to 8 bits
    function automatic logic signed [7:0] score_of(input logic signed [7:0] m,
                                                   input logic signed [7:0] s);
        logic [7:0] half;
        half = 8'(s >>> 1) + {7'd0, s[7] & s[0]};
        return 8'(m + half);
    endfunction

endpackage

// ===== hw/rtl/spsu_update.sv =====
// next-state and result logic for one transaction of the standby parent selector
// depends on spsu_pkg
`timescale 1ns / 1ps

module spsu_update
    import spsu_pkg::*;
(
    input  t_cand_state  i_state,
    input  logic [15:0]  i_active,
    input  t_in_item     i_item,
    input  logic [7:0]   i_replace_margin,
    input  logic [31:0]  i_timeout,
    output t_cand_state  o_state,
    output logic [15:0]  o_active,
    output t_out_item    o_result
);

    logic signed [7:0] new_score;
    logic [31:0]       old_age;
    logic              old_stale;
    logic signed [9:0] need_score;
    logic signed [9:0] new_score_x;
    logic              beats;
    logic              same_cand;
    logic              keep_prev;
    logic [31:0]       new_age;

    // scoring and staleness of the entry as held
    assign new_score   = score_of(i_item.margin, i_item.signal_level);
    assign old_age     = i_item.now_ms - i_state.stamp;
    assign old_stale   = !i_state.valid || (old_age >= i_timeout);
    assign need_score  = {{2{i_state.score[7]}}, i_state.score}
                       + $signed({2'b00, i_replace_margin});
    assign new_score_x = {{2{new_score[7]}}, new_score};
    assign beats       = new_score_x >= need_score;
    assign same_cand   = i_state.valid && (i_item.node_addr == i_state.addr);
    assign keep_prev   = (i_active != ADDR_NONE) && (i_active != ADDR_INVALID)
                       && (i_active != i_item.node_addr);

    // command decode and entry update
    always_comb begin
        o_state  = i_state;
        o_active = i_active;
        case (i_item.command)
            CMD_OBSERVE: begin
                if (i_item.node_addr != i_active) begin
                    if (same_cand) begin
                        o_state.margin = i_item.margin;
                        o_state.signal = i_item.signal_level;
                        o_state.score  = new_score;
                        o_state.stamp  = i_item.now_ms;
                        if (i_item.ext_present) begin
                            o_state.ext       = i_item.ext_addr;
                            o_state.ext_known = 1'b1;
                        end
                    end else if (old_stale || beats) begin
                        o_state.valid     = 1'b1;
                        o_state.addr      = i_item.node_addr;
                        o_state.margin    = i_item.margin;
                        o_state.signal    = i_item.signal_level;
                        o_state.score     = new_score;
                        o_state.stamp     = i_item.now_ms;
                        o_state.ext_known = i_item.ext_present;
                        if (i_item.ext_present) begin
                            o_state.ext = i_item.ext_addr;
                        end
                    end
                end
            end
            CMD_FAILOVER: begin
                o_active = i_item.node_addr;
                if (same_cand) begin
                    o_state.valid = 1'b0;
                    o_state.stamp = i_item.now_ms;
                end
                if (keep_prev) begin
                    o_state.valid     = 1'b1;
                    o_state.addr      = i_active;
                    o_state.margin    = '0;
                    o_state.signal    = DEFAULT_SIGNAL;
                    o_state.score     = DEFAULT_SCORE;
                    o_state.stamp     = i_item.now_ms;
                    o_state.ext_known = 1'b0;
                end
            end
            CMD_TICK: begin
                if (old_stale) begin
                    o_state.valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // report the updated entry at this transaction's time
    assign new_age = i_item.now_ms - o_state.stamp;

    always_comb begin
        o_result.standby_ok      = o_state.valid && (new_age < i_timeout);
        o_result.standby_addr    = o_state.addr;
        o_result.standby_score   = o_state.score;
        o_result.standby_margin  = o_state.margin;
        o_result.standby_signal  = o_state.signal;
        o_result.standby_has_ext = o_state.ext_known;
        o_result.standby_ext     = o_state.ext_known ? o_state.ext : 64'd0;
        o_result.freshness_ms    = o_state.valid ? new_age : FRESH_NONE;
    end

endmodule

// ===== hw/rtl/standby_parent_selector_unit.sv =====
// A transaction is registered in the input register at acceptance and its result
// is registered in the output register when the transaction moves on.
// Throughput: one transaction per cycle unless the output is stalled; the single entry
// is read and written in the same cycle that moves a transaction from input to output.
// Reset (synchronous, active low): no active parent, standby invalid and zeroed,
// replace margin 10, refresh timeout 30000 ms, both pipeline registers empty.
`timescale 1ns / 1ps
`include "standby_parent_selector_unit_defines.svh"

module standby_parent_selector_unit
    import spsu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data
);

    logic        r_in_vld;
    t_in_item    r_in;
    logic        r_out_vld;
    t_out_item   r_out;
    t_cand_state r_state;
    logic [15:0] r_active;
    logic [7:0]  r_replace_margin;
    logic [31:0] r_timeout;

    t_cand_state n_state;
    logic [15:0] n_active;
    t_out_item   n_out;
    logic        adv;

    // a transaction moves on when the output register is free or being drained
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    spsu_update u_update (
        .i_state          (r_state),
        .i_active         (r_active),
        .i_item           (r_in),
        .i_replace_margin (r_replace_margin),
        .i_timeout        (r_timeout),
        .o_state          (n_state),
        .o_active         (n_active),
        .o_result         (n_out)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_margin <= RST_REPLACE_MARGIN;
            r_timeout        <= RST_REFRESH_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPLACE_MARGIN:  r_replace_margin <= i_cfg_data[7:0];
                CFG_REFRESH_TIMEOUT: r_timeout        <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // standby entry and active parent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_active <= ADDR_NONE;
        end else if (adv) begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    `SPSU_ASSERT_NEXT(a_adv_gives_result, adv, r_out_vld, "advance did not produce a result")
    `SPSU_ASSERT_NOW(a_standby_not_active, r_state.valid, r_state.addr != r_active, "standby equals active parent")
    `SPSU_ASSERT_NOW(a_ext_masked, r_out_vld && !r_out.standby_has_ext, r_out.standby_ext == 64'd0, "unknown extended address not zero")
    `SPSU_ASSERT_NOW(a_ok_is_fresh, r_out_vld && r_out.standby_ok, r_out.freshness_ms < r_timeout, "standby reported ok while stale")

endmodule
